// ----- design/ehmc_pkg.sv -----
// Shared constants and types for the edge histogram minimum crossing block.
`default_nettype none

package ehmc_pkg;

	// Default sizes of the histogram and of the row counter
	localparam int DEF_MAX_POSITION = 1024;
	localparam int DEF_MAX_ROWS     = 1024;

	// Fixed field widths
	localparam int WIDTH_W = 10;
	localparam int LEAST_W = 11;

	// Wall generation tag stored with every histogram entry
	localparam int TAG_W = 8;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} state_t;

	// One result item
	typedef struct packed {
		logic [LEAST_W-1:0] least_crossed;
		logic               range_exceeded;
	} result_t;

endpackage

`default_nettype wire

// ----- design/ehmc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
`default_nettype none

module ehmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- design/edge_histogram_min_crossing.sv -----
// Top level of the edge histogram minimum crossing block.
`default_nettype none

// Takes one brick per cycle (width, row end, wall end) and, on the last brick
// of each wall, delivers one result: rows minus the most common interior edge
// count, plus a flag for edge positions at or beyond MAX_POSITION or a row count
// that exceeded MAX_ROWS. Sustained rate is one brick per clock: each interior edge
// is one read-modify-write of the histogram RAM over two stages, with the
// previous write forwarded when consecutive edges hit the same position.
// Histogram entries carry an 8-bit wall tag, so a new wall starts without
// clearing. After reset, and again after every 255th wall when the tag wraps,
// a clearing pass sweeps every RAM address while in_ready is low.
// Results sit in a two-entry output queue; input also stalls while that queue
// cannot take another result.

module edge_histogram_min_crossing
	import ehmc_pkg::*;
#(
	parameter int MAX_POSITION = DEF_MAX_POSITION,
	parameter int MAX_ROWS     = DEF_MAX_ROWS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [WIDTH_W-1:0] brick_width,
	input  wire logic               row_end,
	input  wire logic               wall_end,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [LEAST_W-1:0]      least_crossed,
	output logic                    range_exceeded
);

	localparam int AW     = $clog2(MAX_POSITION);
	localparam int PREF_W = $clog2(MAX_POSITION + 1);
	localparam int SUM_W  = ((PREF_W > WIDTH_W) ? PREF_W : WIDTH_W) + 1;
	localparam int CW     = $clog2(MAX_ROWS + 1);
	localparam int MW     = TAG_W + CW;

	localparam logic [AW-1:0]    LAST_ADDR = AW'(MAX_POSITION - 1);
	localparam logic [SUM_W-1:0] POS_LIMIT = SUM_W'(MAX_POSITION);
	localparam logic [CW-1:0]    ROW_LIMIT = CW'(MAX_ROWS);
	localparam logic [TAG_W-1:0] TAG_LAST  = {TAG_W{1'b1}};
	localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);

	state_t state_q;
	logic [AW-1:0] clr_addr_q;
	logic [TAG_W-1:0] epoch_q;

	logic [PREF_W-1:0] prefix_q;
	logic [CW-1:0] row_total_q;
	logic ovf_q;
	logic [CW-1:0] best_q;

	// Stage 1 registers
	logic v_s1;
	logic [AW-1:0] addr_s1;
	logic wall_s1;
	logic [CW-1:0] rt_s1;
	logic ovf_s1;
	logic fwd_s1;
	logic [CW-1:0] fwd_cnt_s1;

	// Output queue
	result_t ent_q [2];
	logic [1:0] cnt_q;

	// RAM ports
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [MW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [MW-1:0] ram_rdata;

	// Stage 0 signals
	logic acc;
	logic row_last;
	logic [SUM_W-1:0] pos_sum;
	logic in_range;
	logic mem_op;
	logic [CW-1:0] rt_next;
	logic ovf_now;

	// Stage 1 signals
	logic [TAG_W-1:0] rd_tag;
	logic [CW-1:0] rd_cnt;
	logic [CW-1:0] cur_cnt;
	logic [CW-1:0] nxt_cnt;
	logic [CW-1:0] diff;
	result_t res;
	logic pop;

	// Accept while running and the queue has room for a possible result
	assign in_ready = (state_q == ST_RUN) &&
		((cnt_q == 2'd0) || ((cnt_q == 2'd1) && !wall_s1));
	assign acc      = in_valid && in_ready;
	assign row_last = row_end || wall_end;
	assign pos_sum  = SUM_W'(prefix_q) + SUM_W'(brick_width);
	assign in_range = pos_sum < POS_LIMIT;
	assign mem_op   = acc && !row_last && in_range;

	// Saturating row count and sticky range flag as seen after this transfer
	always_comb begin
		rt_next = row_total_q;
		ovf_now = ovf_q;
		if (acc && row_last) begin
			if (row_total_q >= ROW_LIMIT) begin
				ovf_now = 1'b1;
			end else begin
				rt_next = row_total_q + CW'(1);
			end
		end
		if (acc && !row_last && !in_range) begin
			ovf_now = 1'b1;
		end
	end

	// Sequence the clearing pass and the wall tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			epoch_q    <= TAG_FIRST;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_addr_q == LAST_ADDR) begin
						state_q    <= ST_RUN;
						clr_addr_q <= '0;
					end else begin
						clr_addr_q <= clr_addr_q + AW'(1);
					end
				end
				ST_RUN: begin
					if (acc && wall_end) begin
						if (epoch_q == TAG_LAST) begin
							epoch_q <= TAG_FIRST;
							state_q <= ST_CLEAR;
						end else begin
							epoch_q <= epoch_q + TAG_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// Track the row prefix, row count and range flag per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q    <= '0;
			row_total_q <= '0;
			ovf_q       <= 1'b0;
		end else if (acc) begin
			if (row_last) begin
				prefix_q <= '0;
			end else if (in_range) begin
				prefix_q <= pos_sum[PREF_W-1:0];
			end else begin
				prefix_q <= PREF_W'(MAX_POSITION);
			end
			if (wall_end) begin
				row_total_q <= '0;
				ovf_q       <= 1'b0;
			end else begin
				row_total_q <= rt_next;
				ovf_q       <= ovf_now;
			end
		end
	end

	// Advance stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			wall_s1 <= 1'b0;
			fwd_s1  <= 1'b0;
		end else begin
			v_s1    <= mem_op;
			wall_s1 <= acc && wall_end;
			fwd_s1  <= mem_op && v_s1 && (addr_s1 == pos_sum[AW-1:0]);
		end
	end

	// Advance stage 1 payload
	always_ff @(posedge clk) begin
		addr_s1    <= pos_sum[AW-1:0];
		rt_s1      <= rt_next;
		ovf_s1     <= ovf_now;
		fwd_cnt_s1 <= nxt_cnt;
	end

	// Read the counter: forwarded, current wall, or stale (reads as zero)
	assign rd_tag  = ram_rdata[MW-1:CW];
	assign rd_cnt  = ram_rdata[CW-1:0];
	assign cur_cnt = fwd_s1 ? fwd_cnt_s1 : ((rd_tag == epoch_q) ? rd_cnt : '0);
	assign nxt_cnt = (cur_cnt < ROW_LIMIT) ? cur_cnt + CW'(1) : cur_cnt;

	// Drive the RAM write from the clearing pass or the stage 1 update
	always_comb begin
		ram_raddr = pos_sum[AW-1:0];
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = v_s1;
			ram_waddr = addr_s1;
			ram_wdata = {epoch_q, nxt_cnt};
		end
	end

	ehmc_ram #(
		.WIDTH(MW),
		.DEPTH(MAX_POSITION)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Keep the running maximum; drop it at wall end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (wall_s1) begin
			best_q <= '0;
		end else if (v_s1 && (nxt_cnt > best_q)) begin
			best_q <= nxt_cnt;
		end
	end

	// Form the wall result
	assign diff = (best_q <= rt_s1) ? rt_s1 - best_q : '0;
	assign res.least_crossed  = LEAST_W'(diff);
	assign res.range_exceeded = ovf_s1;

	assign pop = out_valid && out_ready;

	// Hold results in a two-entry queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({wall_s1, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({wall_s1, pop})
			2'b10: begin
				ent_q[cnt_q[0]] <= res;
			end
			2'b01: begin
				ent_q[0] <= ent_q[1];
			end
			2'b11: begin
				if (cnt_q == 2'd1) begin
					ent_q[0] <= res;
				end else begin
					ent_q[0] <= ent_q[1];
					ent_q[1] <= res;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = (cnt_q != 2'd0);
	assign least_crossed  = ent_q[0].least_crossed;
	assign range_exceeded = ent_q[0].range_exceeded;

endmodule

`default_nettype wire

// ----- design/ehmc_checker.sv -----
// Port-level assertions for the edge histogram minimum crossing block, with bind.
`default_nettype none

module ehmc_checker
	import ehmc_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic [WIDTH_W-1:0] brick_width,
	input wire logic               row_end,
	input wire logic               wall_end,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [LEAST_W-1:0] least_crossed,
	input wire logic               range_exceeded
);

	// Hold a stalled result and its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(least_crossed) &&
			$stable(range_exceeded))
		else $error("stalled result changed or dropped");

	// Every wall end transfer shows a result, after passing the stage 1 register and the queue count
	a_wall_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && wall_end |-> ##2 out_valid)
		else $error("wall end gave no result");

	// A result appearing from an empty queue comes from a wall end transfer
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && wall_end, 2))
		else $error("result without a wall end");

endmodule

bind edge_histogram_min_crossing ehmc_checker u_ehmc_checker (.*);

`default_nettype wire
